@@ rtl/multilevel_round_robin_scheduler_defines.svh @@
// assertion macros shared by the scheduler
`ifndef MULTILEVEL_ROUND_ROBIN_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_ROUND_ROBIN_SCHEDULER_DEFINES_SVH

// condition and consequence in the same cycle
`define MLRR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence in the cycle after the condition
`define MLRR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/mlrr_pkg.sv @@
package mlrr_pkg;

	localparam int NUM_TASKS   = 16;
	localparam int NUM_LEVELS  = 4;
	localparam int TASK_W      = $clog2(NUM_TASKS);
	localparam int LVL_W       = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int CNT_W       = $clog2(NUM_TASKS + 1);
	localparam int MEM_AW      = LVL_W + TASK_W;
	localparam int MEM_DEPTH   = 2 ** MEM_AW;
	localparam int QUOTA_W     = 3;
	localparam int QUOTA_RESET = 3;
	localparam int CMD_W       = 3;
	localparam int ID_W        = 4;
	localparam int LEVEL_FW    = 5;
	localparam int PICK_W      = 5;
	localparam int STATUS_W    = 3;
	localparam int IN_W        = 16;
	localparam int OUT_W       = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE = 3'd0,
		CMD_RESET  = 3'd1,
		CMD_RUN    = 3'd2,
		CMD_SLEEP  = 3'd3,
		CMD_WAKE   = 3'd4,
		CMD_PICK   = 3'd5,
		CMD_ENTER  = 3'd6,
		CMD_RETURN = 3'd7
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_IGNORED    = 3'd1,
		ST_TABLE_FULL = 3'd2,
		ST_QUEUE_FULL = 3'd3,
		ST_NONE       = 3'd4
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic    latch_item;
		logic    create;
		logic    reset_task;
		logic    set_status;
		status_t status;
		logic    pick_hit;
		logic    set_active;
		logic    clr_active;
		logic    clr_active_tgt;
		logic    run_level;
		logic    add;
		logic    choose;
		logic    pick_sel;
		logic    pick_take;
		logic    rm_start;
		logic    rm_cmp;
		logic    rm_shift;
		logic    out_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic known;
		logic table_full;
		logic tgt_runnable;
		logic tgt_entry;
		logic run_moves;
		logic add_full;
		logic active_none;
		logic pick_none;
		logic rd_ok;
		logic rd_entry;
		logic rm_empty;
		logic rm_match;
		logic rm_more;
		logic out_free;
	} dp_stat_t;

endpackage

@@ rtl/mlrr_ram.sv @@
module mlrr_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/mlrr_ctrl.sv @@
module mlrr_ctrl
	import mlrr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [12:0] {
		S_IDLE     = 13'b0000000000001,
		S_DECODE   = 13'b0000000000010,
		S_RESET2   = 13'b0000000000100,
		S_RUN      = 13'b0000000001000,
		S_RUN2     = 13'b0000000010000,
		S_ADD      = 13'b0000000100000,
		S_CHOOSE   = 13'b0000001000000,
		S_PICK     = 13'b0000010000000,
		S_PICKRD   = 13'b0000100000000,
		S_RM_START = 13'b0001000000000,
		S_RM_CMP   = 13'b0010000000000,
		S_RM_SHW   = 13'b0100000000000,
		S_FIN      = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	state_t ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cmd     = '0;
		cmd.status = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_item = 1'b1;
					state_d        = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.cmd)
					CMD_CREATE: begin
						if (stat.table_full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_TABLE_FULL;
							state_d        = S_FIN;
						end else begin
							cmd.create = 1'b1;
							state_d    = S_RUN;
						end
					end
					CMD_RESET: begin
						if (!stat.known) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_IGNORED;
							state_d        = S_FIN;
						end else if (stat.tgt_runnable) begin
							ret_d   = S_RESET2;
							state_d = S_RM_START;
						end else begin
							state_d = S_RESET2;
						end
					end
					CMD_RUN: begin
						if (!stat.known) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_IGNORED;
							state_d        = S_FIN;
						end else begin
							state_d = S_RUN;
						end
					end
					CMD_SLEEP: begin
						if (!stat.known || !stat.tgt_runnable) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_IGNORED;
							state_d        = S_FIN;
						end else begin
							cmd.clr_active_tgt = 1'b1;
							ret_d              = S_CHOOSE;
							state_d            = S_RM_START;
						end
					end
					CMD_WAKE: begin
						if (!stat.known || stat.tgt_runnable) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_IGNORED;
							state_d        = S_FIN;
						end else begin
							state_d = S_ADD;
						end
					end
					CMD_PICK: begin
						state_d = S_PICK;
					end
					CMD_ENTER: begin
						if (!stat.known || !stat.tgt_runnable) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_IGNORED;
							state_d        = S_FIN;
						end else if (!stat.tgt_entry) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_IGNORED;
							ret_d          = S_FIN;
							state_d        = S_RM_START;
						end else begin
							cmd.set_active = 1'b1;
							state_d        = S_FIN;
						end
					end
					CMD_RETURN: begin
						if (stat.active_none) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_IGNORED;
						end else begin
							cmd.clr_active = 1'b1;
						end
						state_d = S_FIN;
					end
					default: state_d = S_FIN;
				endcase
			end
			S_RESET2: begin
				cmd.reset_task = 1'b1;
				state_d        = S_RUN;
			end
			// leave the old queue first when the level changes
			S_RUN: begin
				if (stat.run_moves) begin
					ret_d   = S_RUN2;
					state_d = S_RM_START;
				end else begin
					state_d = S_RUN2;
				end
			end
			S_RUN2: begin
				cmd.run_level = 1'b1;
				state_d       = stat.tgt_runnable ? S_CHOOSE : S_ADD;
			end
			S_ADD: begin
				if (stat.add_full) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_QUEUE_FULL;
				end else begin
					cmd.add = 1'b1;
				end
				state_d = S_CHOOSE;
			end
			S_CHOOSE: begin
				cmd.choose = 1'b1;
				state_d    = S_FIN;
			end
			S_PICK: begin
				if (stat.pick_none) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_NONE;
					state_d        = S_FIN;
				end else begin
					cmd.pick_sel = 1'b1;
					state_d      = S_PICKRD;
				end
			end
			// queue entry is back from memory
			S_PICKRD: begin
				cmd.pick_take = 1'b1;
				if (!stat.rd_ok) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_NONE;
					state_d        = S_FIN;
				end else if (!stat.rd_entry) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_NONE;
					ret_d          = S_FIN;
					state_d        = S_RM_START;
				end else begin
					cmd.pick_hit = 1'b1;
					state_d      = S_FIN;
				end
			end
			// removal: search the queue, then close the gap
			S_RM_START: begin
				cmd.rm_start = 1'b1;
				state_d      = stat.rm_empty ? ret_q : S_RM_CMP;
			end
			S_RM_CMP: begin
				cmd.rm_cmp = 1'b1;
				if (stat.rm_more) begin
					state_d = stat.rm_match ? S_RM_SHW : S_RM_CMP;
				end else begin
					state_d = ret_q;
				end
			end
			S_RM_SHW: begin
				cmd.rm_shift = 1'b1;
				state_d      = stat.rm_more ? S_RM_SHW : ret_q;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ rtl/mlrr_dp.sv @@
module mlrr_dp
	import mlrr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [IN_W-1:0]    in_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [QUOTA_W-1:0] cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [OUT_W-1:0]   out_data,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat
);

	// item fields
	cmd_t                cmd_q;
	logic [ID_W-1:0]     tid_q;
	logic [LEVEL_FW-1:0] level_q;
	logic                ev_q;

	// scheduler state
	logic [QUOTA_W-1:0] quota_q;
	logic [CNT_W-1:0]   count_q [NUM_LEVELS];
	logic [TASK_W-1:0]  ptr_q   [NUM_LEVELS];
	logic               runnable_q [NUM_TASKS];
	logic               entry_q    [NUM_TASKS];
	logic [LVL_W-1:0]   lvl_q      [NUM_TASKS];
	logic [CNT_W-1:0]   task_count_q;
	logic [PICK_W-1:0]  active_q;
	logic [LVL_W-1:0]   al_q;
	logic [QUOTA_W-1:0] ql_q;

	// work registers
	logic [TASK_W-1:0]   tgt_q;
	logic [LVL_W-1:0]    rm_lv_q;
	logic [TASK_W-1:0]   idx_q;
	logic [PICK_W-1:0]   picked_q;
	status_t             status_q;
	logic                out_valid_q;
	logic [OUT_W-1:0]    out_data_q;

	// memory
	logic                we;
	logic [MEM_AW-1:0]   waddr, raddr;
	logic [TASK_W-1:0]   wdata, rdata;

	// combinational helpers
	logic [LVL_W-1:0]  run_lv;
	logic [LVL_W-1:0]  tgt_lv;
	logic [LVL_W-1:0]  pick_lv, rot_lv, first_lv;
	logic              cur_ok, rot_found, any_found;
	logic [TASK_W-1:0] pick_p, pick_p1;
	logic [CNT_W-1:0]  pick_cnt;
	logic [CNT_W-1:0]  rm_cnt;
	logic [CNT_W-1:0]  rm_n;
	logic [TASK_W-1:0] rm_p;

	assign cfg_ready = 1'b1;
	assign tgt_lv    = lvl_q[tgt_q];
	assign rm_cnt    = count_q[rm_lv_q];

	// level a run asks for
	always_comb begin
		if (level_q[LEVEL_FW-1]) begin
			run_lv = tgt_lv;
		end else if (int'(level_q) >= NUM_LEVELS) begin
			run_lv = LVL_W'(NUM_LEVELS - 1);
		end else begin
			run_lv = LVL_W'(level_q);
		end
	end

	// level search for pick and for choosing a level
	always_comb begin
		int l;
		cur_ok    = (count_q[al_q] != '0) && (ql_q != '0);
		rot_found = 1'b0;
		rot_lv    = '0;
		any_found = 1'b0;
		first_lv  = '0;
		for (int s = 1; s <= NUM_LEVELS; s++) begin
			l = int'(al_q) + s;
			if (l >= NUM_LEVELS) begin
				l = l - NUM_LEVELS;
			end
			if (!rot_found && count_q[l] != '0) begin
				rot_found = 1'b1;
				rot_lv    = LVL_W'(l);
			end
		end
		for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
			if (count_q[k] != '0) begin
				any_found = 1'b1;
				first_lv  = LVL_W'(k);
			end
		end
		pick_lv  = cur_ok ? al_q : rot_lv;
		pick_cnt = count_q[pick_lv];
		pick_p   = (CNT_W'(ptr_q[pick_lv]) >= pick_cnt) ? '0 : ptr_q[pick_lv];
		pick_p1  = (CNT_W'(pick_p) + 1'b1 >= pick_cnt) ? '0 : TASK_W'(pick_p + 1'b1);
	end

	// pointer after removing the entry at idx_q
	always_comb begin
		rm_n = rm_cnt - 1'b1;
		rm_p = ptr_q[rm_lv_q];
		if (idx_q < rm_p) begin
			rm_p = rm_p - 1'b1;
		end
		if (CNT_W'(rm_p) >= rm_n) begin
			rm_p = '0;
		end
	end

	// memory port selection
	always_comb begin
		we    = 1'b0;
		waddr = {tgt_lv, count_q[tgt_lv][TASK_W-1:0]};
		wdata = tgt_q;
		raddr = {pick_lv, pick_p};
		priority if (cmd.add) begin
			we = 1'b1;
		end else if (cmd.rm_shift) begin
			we    = 1'b1;
			waddr = {rm_lv_q, idx_q};
			wdata = rdata;
			raddr = {rm_lv_q, TASK_W'(idx_q + 2'd2)};
		end else if (cmd.rm_start) begin
			raddr = {tgt_lv, TASK_W'(0)};
		end else if (cmd.rm_cmp) begin
			raddr = {rm_lv_q, TASK_W'(idx_q + 1'b1)};
		end
	end

	mlrr_ram #(
		.WIDTH(TASK_W),
		.DEPTH(MEM_DEPTH)
	) u_queue_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// item and result registers
	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			cmd_q    <= cmd_t'(in_data[CMD_W-1:0]);
			tid_q    <= in_data[CMD_W +: ID_W];
			level_q  <= in_data[CMD_W+ID_W +: LEVEL_FW];
			ev_q     <= in_data[CMD_W+ID_W+LEVEL_FW];
			tgt_q    <= TASK_W'(in_data[CMD_W +: ID_W]);
			picked_q <= '1;
			status_q <= ST_OK;
		end
		if (cmd.create) begin
			tgt_q    <= task_count_q[TASK_W-1:0];
			picked_q <= PICK_W'(task_count_q);
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.pick_take) begin
			tgt_q <= rdata;
		end
		if (cmd.pick_hit) begin
			picked_q <= PICK_W'(rdata);
		end
		if (cmd.rm_start) begin
			rm_lv_q <= tgt_lv;
			idx_q   <= '0;
		end
		if (cmd.rm_cmp && !(rdata == tgt_q)) begin
			idx_q <= TASK_W'(idx_q + 1'b1);
		end
		if (cmd.rm_shift) begin
			idx_q <= TASK_W'(idx_q + 1'b1);
		end
		if (cmd.out_load) begin
			out_data_q <= OUT_W'({active_q, status_q, picked_q});
		end
	end

	// scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quota_q      <= QUOTA_W'(QUOTA_RESET);
			task_count_q <= '0;
			active_q     <= '1;
			al_q         <= '0;
			ql_q         <= QUOTA_W'(QUOTA_RESET);
			out_valid_q  <= 1'b0;
			for (int k = 0; k < NUM_LEVELS; k++) begin
				count_q[k] <= '0;
				ptr_q[k]   <= '0;
			end
			for (int k = 0; k < NUM_TASKS; k++) begin
				runnable_q[k] <= 1'b0;
				entry_q[k]    <= 1'b0;
				lvl_q[k]      <= '0;
			end
		end else begin
			// quota register, zero saturates to one
			if (cfg_valid) begin
				quota_q <= (cfg_data == '0) ? QUOTA_W'(1) : cfg_data;
			end
			if (cmd.create) begin
				task_count_q                          <= task_count_q + 1'b1;
				runnable_q[task_count_q[TASK_W-1:0]] <= 1'b0;
				lvl_q[task_count_q[TASK_W-1:0]]      <= '0;
				entry_q[task_count_q[TASK_W-1:0]]    <= ev_q;
			end
			if (cmd.reset_task) begin
				entry_q[tgt_q]    <= ev_q;
				runnable_q[tgt_q] <= 1'b0;
				lvl_q[tgt_q]      <= '0;
			end
			if (cmd.set_active) begin
				active_q <= PICK_W'(tgt_q);
			end
			if (cmd.clr_active || (cmd.clr_active_tgt && active_q == PICK_W'(tgt_q))) begin
				active_q <= '1;
			end
			if (cmd.run_level) begin
				lvl_q[tgt_q] <= run_lv;
			end
			if (cmd.add) begin
				count_q[tgt_lv]   <= count_q[tgt_lv] + 1'b1;
				runnable_q[tgt_q] <= 1'b1;
			end
			if (cmd.choose) begin
				if (any_found) begin
					al_q <= first_lv;
					ql_q <= (first_lv == '0) ? quota_q : QUOTA_W'(1);
				end else begin
					al_q <= '0;
					ql_q <= quota_q;
				end
			end
			// pick: spend quota or rotate, advance the pointer
			if (cmd.pick_sel) begin
				if (cur_ok) begin
					ql_q <= ql_q - 1'b1;
				end else begin
					al_q <= rot_lv;
					ql_q <= (rot_lv == '0) ? QUOTA_W'(quota_q - 1'b1) : '0;
				end
				ptr_q[pick_lv] <= pick_p1;
			end
			if (cmd.rm_start) begin
				runnable_q[tgt_q] <= 1'b0;
			end
			if (cmd.rm_cmp && rdata == tgt_q) begin
				count_q[rm_lv_q] <= rm_n;
				ptr_q[rm_lv_q]   <= rm_p;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// status towards the controller
	always_comb begin
		stat              = '0;
		stat.cmd          = cmd_q;
		stat.known        = int'(tid_q) < int'(task_count_q);
		stat.table_full   = int'(task_count_q) >= NUM_TASKS;
		stat.tgt_runnable = runnable_q[tgt_q];
		stat.tgt_entry    = entry_q[tgt_q];
		stat.run_moves    = runnable_q[tgt_q] && (tgt_lv != run_lv);
		stat.add_full     = int'(count_q[tgt_lv]) >= NUM_TASKS;
		stat.active_none  = active_q[PICK_W-1];
		stat.pick_none    = !cur_ok && !rot_found;
		stat.rd_ok        = (CNT_W'(rdata) < task_count_q) && runnable_q[rdata];
		stat.rd_entry     = entry_q[rdata];
		stat.rm_empty     = (count_q[tgt_lv] == '0);
		stat.rm_match     = (rdata == tgt_q);
		stat.rm_more      = (CNT_W'(idx_q) + 1'b1) < rm_cnt;
		stat.out_free     = !out_valid_q || out_ready;
	end

endmodule

@@ rtl/multilevel_round_robin_scheduler.sv @@
// Multilevel round-robin task scheduler: one command item in, one result item out. Each command
// runs through a control sequencer over a register datapath and a queue RAM holding one
// round-robin list per level. A reset passes the most states of the commands that remove no
// task. Any command that removes a task from its queue (sleep, a level change, a reset of a
// runnable task, a pick or enter of a task with a null entry) adds a serial search and
// compaction of that queue, one RAM entry per cycle. A new command is accepted while the
// previous result still waits at the output. The quota register may be written at any time
// between items.
module multilevel_round_robin_scheduler
	import mlrr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// cmd[2:0], task_id[6:3], level[11:7], entry_valid[12], zero fill
	input  logic [IN_W-1:0]    s_axis_tdata,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// picked_task[4:0], status[7:5], current_task[12:8], zero fill
	output logic [OUT_W-1:0]   m_axis_tdata,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [QUOTA_W-1:0] cfg_data
);

	`include "multilevel_round_robin_scheduler_defines.svh"

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	mlrr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.stat    (dp_stat),
		.cmd     (dp_cmd)
	);

	mlrr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (s_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata),
		.cmd      (dp_cmd),
		.stat     (dp_stat)
	);

	// not ready in the cycle after taking an item
	`MLRR_ASSERT_NEXT(a_busy_after_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after item")

	// nothing runnable always reports no task
	`MLRR_ASSERT_NOW(a_none_no_task, m_axis_tvalid && m_axis_tdata[7:5] == ST_NONE, m_axis_tdata[4:0] == 5'h1f, "task with none status")

	// status code stays in range
	`MLRR_ASSERT_NOW(a_status_range, m_axis_tvalid, m_axis_tdata[7:5] <= ST_NONE, "bad status code")

endmodule

@@ tb/tb_multilevel_round_robin_scheduler.sv @@
module tb_multilevel_round_robin_scheduler
	import mlrr_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [4:0] picked;
		logic [2:0] status;
		logic [4:0] current;
	} sched_result_t;

	// scheduler state mirror and expected result store
	class sched_scoreboard;
		logic [3:0] queue_mem [NUM_LEVELS][NUM_TASKS];
		int unsigned q_count [NUM_LEVELS];
		int unsigned q_ptr [NUM_LEVELS];
		bit runnable [NUM_TASKS];
		int unsigned lvl_of [NUM_TASKS];
		bit entry_ok [NUM_TASKS];
		int unsigned n_tasks;
		int cur_task;
		int unsigned cur_level;
		int unsigned quota_left;
		int unsigned quota;
		sched_result_t pending [$];
		int errors;

		function new();
			quota = QUOTA_RESET;
			n_tasks = 0;
			cur_task = -1;
			cur_level = 0;
			quota_left = QUOTA_RESET;
			errors = 0;
			foreach (q_count[i]) begin
				q_count[i] = 0;
				q_ptr[i] = 0;
			end
			foreach (runnable[i]) begin
				runnable[i] = 0;
				lvl_of[i] = 0;
				entry_ok[i] = 0;
			end
		endfunction

		function void set_quota(logic [2:0] v);
			quota = (v == 3'd0) ? 1 : 32'(v);
		endfunction

		function status_t enqueue(int unsigned t);
			int unsigned lv;
			lv = lvl_of[t];
			if (q_count[lv] >= NUM_TASKS)
				return ST_QUEUE_FULL;
			queue_mem[lv][q_count[lv]] = 4'(t);
			q_count[lv]++;
			runnable[t] = 1;
			return ST_OK;
		endfunction

		function void dequeue(int unsigned t);
			int unsigned lv, n, i;
			lv = lvl_of[t];
			runnable[t] = 0;
			n = q_count[lv];
			for (i = 0; i < n; i++)
				if (32'(queue_mem[lv][i]) == t)
					break;
			if (i == n)
				return;
			n--;
			q_count[lv] = n;
			if (i < q_ptr[lv])
				q_ptr[lv]--;
			if (q_ptr[lv] >= n)
				q_ptr[lv] = 0;
			for (; i < n; i++)
				queue_mem[lv][i] = queue_mem[lv][i + 1];
		endfunction

		function void pick_level();
			for (int i = 0; i < NUM_LEVELS; i++) begin
				if (q_count[i] > 0) begin
					cur_level = i;
					quota_left = (i == 0) ? quota : 1;
					return;
				end
			end
			cur_level = 0;
			quota_left = quota;
		endfunction

		function status_t place(int unsigned t, int req);
			int unsigned lv;
			status_t st;
			st = ST_OK;
			lv = (req < 0) ? lvl_of[t] : req;
			if (lv >= NUM_LEVELS)
				lv = NUM_LEVELS - 1;
			if (runnable[t] && lvl_of[t] != lv)
				dequeue(t);
			lvl_of[t] = lv;
			if (!runnable[t])
				st = enqueue(t);
			pick_level();
			return st;
		endfunction

		function int next_task();
			int chosen;
			int unsigned lv, p, t;
			chosen = -1;
			if (q_count[cur_level] > 0 && quota_left > 0) begin
				chosen = cur_level;
				quota_left--;
			end else begin
				for (int s = 1; s <= NUM_LEVELS; s++) begin
					lv = (cur_level + s) % NUM_LEVELS;
					if (q_count[lv] > 0) begin
						chosen = lv;
						cur_level = lv;
						quota_left = (lv == 0) ? quota - 1 : 0;
						break;
					end
				end
			end
			if (chosen < 0)
				return -1;
			lv = chosen;
			p = q_ptr[lv];
			if (p >= q_count[lv])
				p = 0;
			t = 32'(queue_mem[lv][p]);
			p++;
			if (p >= q_count[lv])
				p = 0;
			q_ptr[lv] = p;
			if (t >= n_tasks || !runnable[t])
				return -1;
			if (!entry_ok[t]) begin
				dequeue(t);
				return -1;
			end
			return t;
		endfunction

		function void note_command(logic [15:0] d);
			cmd_t c;
			int unsigned t;
			int req;
			bit ev, known;
			int picked;
			status_t st;
			sched_result_t r;
			c = cmd_t'(d[2:0]);
			t = 32'(d[6:3]);
			req = 32'($signed(d[11:7]));
			ev = d[12];
			picked = -1;
			st = ST_OK;
			known = t < n_tasks;
			case (c)
				CMD_CREATE: begin
					if (n_tasks >= NUM_TASKS) begin
						st = ST_TABLE_FULL;
					end else begin
						t = n_tasks;
						n_tasks++;
						runnable[t] = 0;
						lvl_of[t] = 0;
						entry_ok[t] = ev;
						st = place(t, req);
						picked = t;
					end
				end
				CMD_RESET: begin
					if (!known) begin
						st = ST_IGNORED;
					end else begin
						if (runnable[t])
							dequeue(t);
						entry_ok[t] = ev;
						runnable[t] = 0;
						lvl_of[t] = 0;
						st = place(t, req);
					end
				end
				CMD_RUN: st = known ? place(t, req) : ST_IGNORED;
				CMD_SLEEP: begin
					if (!known || !runnable[t]) begin
						st = ST_IGNORED;
					end else begin
						dequeue(t);
						pick_level();
						if (cur_task == int'(t))
							cur_task = -1;
					end
				end
				CMD_WAKE: begin
					if (!known || runnable[t]) begin
						st = ST_IGNORED;
					end else begin
						st = enqueue(t);
						pick_level();
					end
				end
				CMD_PICK: begin
					picked = next_task();
					if (picked < 0)
						st = ST_NONE;
				end
				CMD_ENTER: begin
					if (!known || !runnable[t]) begin
						st = ST_IGNORED;
					end else if (!entry_ok[t]) begin
						dequeue(t);
						st = ST_IGNORED;
					end else begin
						cur_task = t;
					end
				end
				default: begin
					if (cur_task < 0)
						st = ST_IGNORED;
					else
						cur_task = -1;
				end
			endcase
			r.picked = picked[4:0];
			r.status = st;
			r.current = cur_task[4:0];
			pending.push_back(r);
		endfunction

		task report_mismatch(string msg);
			$display("error: %s", msg);
			errors++;
		endtask

		task check_result(logic [15:0] d);
			sched_result_t want;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", d));
				return;
			end
			want = pending.pop_front();
			if (d[4:0] !== want.picked)
				report_mismatch($sformatf("picked %h want %h", d[4:0], want.picked));
			if (d[7:5] !== want.status)
				report_mismatch($sformatf("status %h want %h", d[7:5], want.status));
			if (d[12:8] !== want.current)
				report_mismatch($sformatf("current %h want %h", d[12:8], want.current));
			if (d[15:13] !== 3'b000)
				report_mismatch($sformatf("fill bits %h", d[15:13]));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [QUOTA_W-1:0] cfg_data = '0;

	sched_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	longint unsigned cycle_count = 0;
	localparam longint unsigned CYCLE_LIMIT = 2000000;

	multilevel_round_robin_scheduler i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("multilevel_round_robin_scheduler: mismatch");
			$finish;
		end
	end

	// result side: random stall and check
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// send one command item, with optional idle gaps before it
	task automatic send_command(cmd_t c, logic [3:0] t, logic [4:0] lv, logic ev);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {3'b000, ev, lv, t, c};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_command(s_axis_tdata);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_quota(logic [2:0] v);
		drain();
		cfg_valid <= 1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_quota(v);
		cfg_valid <= 0;
	endtask

	// mostly valid ids, sometimes any, with levels around the useful range
	task automatic random_command();
		cmd_t c;
		logic [3:0] t;
		logic [4:0] lv;
		int r;
		r = $urandom_range(99);
		if (r < 12)
			c = CMD_CREATE;
		else if (r < 40)
			c = CMD_PICK;
		else
			c = cmd_t'(3'($urandom_range(7)));
		if (sb.n_tasks > 0 && $urandom_range(9) < 8)
			t = 4'($urandom_range(sb.n_tasks - 1));
		else
			t = 4'($urandom);
		r = $urandom_range(9);
		lv = (r < 6) ? 5'($urandom_range(3)) : (r < 8) ? 5'h1f : 5'($urandom);
		send_command(c, t, lv, $urandom_range(9) < 8);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty pick, return while os runs, unknown task
		send_command(CMD_PICK, 4'd0, 5'd0, 1'b0);
		send_command(CMD_RETURN, 4'd0, 5'd0, 1'b0);
		send_command(CMD_RUN, 4'hf, 5'h0f, 1'b1);
		send_command(CMD_CREATE, 4'd0, 5'h1f, 1'b1);
		send_command(CMD_CREATE, 4'd0, 5'h0f, 1'b1);
		send_command(CMD_CREATE, 4'd0, 5'h10, 1'b0);
		send_command(CMD_CREATE, 4'd0, 5'd1, 1'b1);
		send_command(CMD_PICK, 4'd0, 5'd0, 1'b0);
		send_command(CMD_PICK, 4'd0, 5'd0, 1'b0);
		send_command(CMD_PICK, 4'd0, 5'd0, 1'b0);
		send_command(CMD_ENTER, 4'd2, 5'd0, 1'b0);
		send_command(CMD_ENTER, 4'd1, 5'd0, 1'b0);
		send_command(CMD_SLEEP, 4'd1, 5'd0, 1'b0);
		send_command(CMD_SLEEP, 4'd1, 5'd0, 1'b0);
		send_command(CMD_WAKE, 4'd1, 5'd0, 1'b0);
		send_command(CMD_WAKE, 4'd1, 5'd0, 1'b0);
		send_command(CMD_RUN, 4'd0, 5'd2, 1'b0);
		send_command(CMD_RESET, 4'd3, 5'd3, 1'b0);
		send_command(CMD_ENTER, 4'd0, 5'd0, 1'b0);
		send_command(CMD_RETURN, 4'd0, 5'd0, 1'b0);
		repeat (14) send_command(CMD_CREATE, 4'd0, 5'($urandom_range(3)), 1'b1);
		write_quota(3'd0);
		write_quota(3'd7);

		// random phases with varying idling and quota
		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 3)
				0: begin send_idle_pct = 8; recv_idle_pct = 55; end
				1: begin send_idle_pct = 55; recv_idle_pct = 8; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			if (ph == 3) begin
				// fresh reset of all task state is impossible, so refill via resets
				for (int k = 0; k < NUM_TASKS; k++)
					send_command(CMD_RESET, 4'(k), 5'($urandom_range(3)),
						1'($urandom_range(1)));
			end
			repeat (165) random_command();
			write_quota(3'($urandom_range(7)));
		end
		write_quota(3'd1);
		repeat (20) random_command();
		send_idle_pct = 0;
		recv_idle_pct = 0;

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("multilevel_round_robin_scheduler: match");
		else
			$display("multilevel_round_robin_scheduler: mismatch");
		$finish;
	end
endmodule
